/* design/slqv_pkg.sv */
// shared types, constants and helpers of the sprite and line quad vertex generator
// no dependencies
package slqv_pkg;

  localparam int COORD_BITS  = 24;
  localparam int ANGLE_BITS  = 16;
  localparam int TEX_BITS    = 16;
  localparam int RGBA_BITS   = 32;
  localparam int THICK_BITS  = COORD_BITS - 1;
  localparam int Q16_BITS    = 16;
  localparam int QS_BITS     = Q16_BITS + 1;
  localparam int SC_BITS     = Q16_BITS + 2;
  localparam int SIN_SH      = Q16_BITS - (ANGLE_BITS - 2);
  localparam int PROD_BITS   = COORD_BITS + SC_BITS;
  localparam int ACC_BITS    = PROD_BITS + 4;
  localparam int ROUND_SHIFT = Q16_BITS + 1;
  localparam int SAT_IN_BITS = ACC_BITS - ROUND_SHIFT;
  localparam int NRM_BITS    = 30;
  localparam int SQ_BITS     = 2 * NRM_BITS;
  localparam int SUM_BITS    = SQ_BITS + 2;
  localparam int LEN_BITS    = NRM_BITS + 1;
  localparam int NUM_BITS    = NRM_BITS + THICK_BITS;
  localparam int REM_BITS    = NUM_BITS + 2;
  localparam int DIV_Q_BITS  = THICK_BITS + 1;
  localparam int DSH_BITS    = LEN_BITS + 1 + DIV_Q_BITS;
  localparam int CNT_BITS    = $clog2(DIV_Q_BITS);
  localparam int N_BITS      = DIV_Q_BITS + 1;
  localparam int QDEPTH      = 2;
  localparam int QPTR_BITS   = $clog2(QDEPTH);
  localparam int QCNT_BITS   = $clog2(QDEPTH + 1);

  localparam logic OP_SPRITE = 1'b0;
  localparam logic OP_LINE   = 1'b1;

  localparam logic [1:0] CORNER_LAST = 2'd3;

  localparam logic [QS_BITS-1:0]  SIN_A   = QS_BITS'(102944);
  localparam logic [Q16_BITS-1:0] SIN_B   = Q16_BITS'(42048);
  localparam logic [Q16_BITS-1:0] SIN_C   = Q16_BITS'(4640);
  localparam logic [QS_BITS-1:0]  ONE_Q16 = QS_BITS'(65536);

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic                          op;
    logic signed [COORD_BITS-1:0]  fx;
    logic signed [COORD_BITS-1:0]  fy;
    logic signed [COORD_BITS-1:0]  gx;
    logic signed [COORD_BITS-1:0]  gy;
    logic [ANGLE_BITS-1:0]         rot;
    logic [THICK_BITS-1:0]         thick;
    logic [TEX_BITS-1:0]           u0;
    logic [TEX_BITS-1:0]           v0;
    logic [TEX_BITS-1:0]           u1;
    logic [TEX_BITS-1:0]           v1;
    logic [RGBA_BITS-1:0]          rgba;
  } item_t;

  typedef struct packed {
    logic                          op;
    logic signed [PROD_BITS-1:0]   bx;
    logic signed [PROD_BITS-1:0]   by;
    logic signed [PROD_BITS-1:0]   p1;
    logic signed [PROD_BITS-1:0]   p2;
    logic signed [PROD_BITS-1:0]   p3;
    logic signed [PROD_BITS-1:0]   p4;
    logic signed [COORD_BITS-1:0]  fx;
    logic signed [COORD_BITS-1:0]  fy;
    logic signed [COORD_BITS-1:0]  gx;
    logic signed [COORD_BITS-1:0]  gy;
    logic signed [N_BITS-1:0]      nx;
    logic signed [N_BITS-1:0]      ny;
    logic [TEX_BITS-1:0]           u0;
    logic [TEX_BITS-1:0]           v0;
    logic [TEX_BITS-1:0]           u1;
    logic [TEX_BITS-1:0]           v1;
    logic [RGBA_BITS-1:0]          rgba;
  } job_t;

  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [SAT_IN_BITS-1:0] v
  );
    logic signed [COORD_BITS-1:0] r;
    if (v > SAT_IN_BITS'(COORD_MAX)) begin
      r = COORD_MAX;
    end else if (v < SAT_IN_BITS'(COORD_MIN)) begin
      r = COORD_MIN;
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

/* design/slqv_front.sv */
// front end: accepts primitives, drops zero-length lines, two-entry queue
// depends on slqv_pkg
module slqv_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  slqv_pkg::item_t in_item,
  output logic           q_vld,
  output slqv_pkg::item_t q_item,
  input  logic           q_pop
);

  slqv_pkg::item_t                   mem_r [slqv_pkg::QDEPTH];
  logic [slqv_pkg::QPTR_BITS-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [slqv_pkg::QCNT_BITS-1:0]    cnt_r, cnt_nxt;
  logic                              drop, push;

  assign in_stall = (cnt_r == slqv_pkg::QCNT_BITS'(slqv_pkg::QDEPTH));
  assign drop = (in_item.op == slqv_pkg::OP_LINE) && (in_item.fx == in_item.gx) &&
                (in_item.fy == in_item.gy);
  assign push = in_valid && !in_stall && !drop;
  assign q_vld = (cnt_r != '0);
  assign q_item = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? slqv_pkg::QPTR_BITS'(wr_r + 1'b1) : wr_r;
    rd_nxt  = q_pop ? slqv_pkg::QPTR_BITS'(rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= in_item;
    end
  end

endmodule

/* design/slqv_back.sv */
// back end: sine/cosine and corner products for sprites, normal vector for lines
// depends on slqv_pkg; feeds slqv_emit through a one-job result register
module slqv_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_vld,
  input  slqv_pkg::item_t q_item,
  output logic            q_pop,
  output logic            res_vld,
  output slqv_pkg::job_t  res,
  input  logic            res_take
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_SIN1   = 14'b00000000000010,
    S_SIN2   = 14'b00000000000100,
    S_SIN3   = 14'b00000000001000,
    S_SIN4   = 14'b00000000010000,
    S_PROD   = 14'b00000000100000,
    S_LSTART = 14'b00000001000000,
    S_LNORM  = 14'b00000010000000,
    S_LSQR   = 14'b00000100000000,
    S_LSUM   = 14'b00001000000000,
    S_LROOT  = 14'b00010000000000,
    S_LDIVI  = 14'b00100000000000,
    S_LDIV   = 14'b01000000000000,
    S_LFIN   = 14'b10000000000000
  } state_t;

  localparam int QB = slqv_pkg::QS_BITS;
  localparam int CB = slqv_pkg::COORD_BITS;
  localparam int PB = slqv_pkg::PROD_BITS;

  state_t state_r, state_nxt;
  slqv_pkg::item_t it_r;
  slqv_pkg::job_t  res_r;
  logic            res_vld_r;

  logic [QB-1:0]                 x2a_r, x2b_r, t2a_r, t2b_r;
  logic [slqv_pkg::Q16_BITS-1:0] t1a_r, t1b_r;
  logic signed [slqv_pkg::SC_BITS-1:0] s_r, c_r;

  logic [slqv_pkg::NRM_BITS-1:0] mx_r, my_r;
  logic                          dxneg_r, dypos_r;
  logic [slqv_pkg::SQ_BITS-1:0]  sqx_r, sqy_r;
  logic [slqv_pkg::NUM_BITS-1:0] numx_r, numy_r;
  logic [slqv_pkg::SUM_BITS-1:0] v_r;
  logic [slqv_pkg::SUM_BITS:0]   root_r, bit_r;
  logic [slqv_pkg::REM_BITS-1:0] remx_r, remy_r;
  logic [slqv_pkg::DSH_BITS-1:0] dsh_r;
  logic [slqv_pkg::DIV_Q_BITS-1:0] qx_r, qy_r;
  logic [slqv_pkg::CNT_BITS-1:0] cnt_r;

  logic [QB-1:0]          xa, xb, pa, pb;
  logic [2*QB-1:0]        sqa, sqb, ma, mb;
  logic [QB+QB-2:0]       ka, kb;
  logic [2*QB-2:0]        ha, hb;
  logic [1:0]             quad;
  logic signed [slqv_pkg::SC_BITS-1:0] sp, sr, s_nxt, c_nxt;
  logic signed [CB+1:0]   cx, cy;
  logic signed [CB:0]     dx, dy;
  logic [CB:0]            adx, ady;
  logic [slqv_pkg::NRM_BITS-1:0] orv;
  logic [slqv_pkg::SUM_BITS+1:0] trial;
  logic [slqv_pkg::LEN_BITS-1:0] len;
  logic                   gex, gey, slot_free;
  logic signed [slqv_pkg::N_BITS-1:0] nxm, nym;

  assign xa = QB'(it_r.rot[slqv_pkg::ANGLE_BITS-3:0]) << slqv_pkg::SIN_SH;
  assign xb = slqv_pkg::ONE_Q16 - xa;
  assign quad = it_r.rot[slqv_pkg::ANGLE_BITS-1 -: 2];

  assign sqa = (2*QB)'(xa) * (2*QB)'(xa);
  assign sqb = (2*QB)'(xb) * (2*QB)'(xb);
  assign ka  = (QB+QB-1)'(slqv_pkg::SIN_C) * (QB+QB-1)'(x2a_r);
  assign kb  = (QB+QB-1)'(slqv_pkg::SIN_C) * (QB+QB-1)'(x2b_r);
  assign ha  = (2*QB-1)'(x2a_r) * (2*QB-1)'(t1a_r);
  assign hb  = (2*QB-1)'(x2b_r) * (2*QB-1)'(t1b_r);
  assign ma  = (2*QB)'(xa) * (2*QB)'(t2a_r);
  assign mb  = (2*QB)'(xb) * (2*QB)'(t2b_r);

  always_comb begin
    pa = (ma[2*QB-1:slqv_pkg::Q16_BITS] > (QB+1)'(slqv_pkg::ONE_Q16)) ?
         slqv_pkg::ONE_Q16 : ma[slqv_pkg::Q16_BITS +: QB];
    pb = (mb[2*QB-1:slqv_pkg::Q16_BITS] > (QB+1)'(slqv_pkg::ONE_Q16)) ?
         slqv_pkg::ONE_Q16 : mb[slqv_pkg::Q16_BITS +: QB];
    sp = signed'({1'b0, pa});
    sr = signed'({1'b0, pb});
    case (quad)
      2'd0: begin
        s_nxt = sp;
        c_nxt = sr;
      end
      2'd1: begin
        s_nxt = sr;
        c_nxt = -sp;
      end
      2'd2: begin
        s_nxt = -sp;
        c_nxt = -sr;
      end
      default: begin
        s_nxt = -sr;
        c_nxt = sp;
      end
    endcase
  end

  assign cx = (CB+2)'(it_r.fx) + (CB+2)'(it_r.fx) + (CB+2)'(it_r.gx);
  assign cy = (CB+2)'(it_r.fy) + (CB+2)'(it_r.fy) + (CB+2)'(it_r.gy);
  assign dx = (CB+1)'(it_r.gx) - (CB+1)'(it_r.fx);
  assign dy = (CB+1)'(it_r.gy) - (CB+1)'(it_r.fy);
  assign adx = dx[CB] ? unsigned'(-dx) : unsigned'(dx);
  assign ady = dy[CB] ? unsigned'(-dy) : unsigned'(dy);
  assign orv = mx_r | my_r;
  assign trial = (slqv_pkg::SUM_BITS+2)'(root_r) + (slqv_pkg::SUM_BITS+2)'(bit_r);
  assign len = root_r[slqv_pkg::LEN_BITS-1:0];
  assign gex = (slqv_pkg::DSH_BITS'(remx_r) >= dsh_r);
  assign gey = (slqv_pkg::DSH_BITS'(remy_r) >= dsh_r);
  assign nxm = signed'(slqv_pkg::N_BITS'(qx_r));
  assign nym = signed'(slqv_pkg::N_BITS'(qy_r));
  assign slot_free = !res_vld_r || res_take;

  assign q_pop   = (state_r == S_IDLE) && q_vld;
  assign res_vld = res_vld_r;
  assign res     = res_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_vld) begin
          state_nxt = (q_item.op == slqv_pkg::OP_LINE) ? S_LSTART : S_SIN1;
        end
      end
      S_SIN1:   state_nxt = S_SIN2;
      S_SIN2:   state_nxt = S_SIN3;
      S_SIN3:   state_nxt = S_SIN4;
      S_SIN4:   state_nxt = S_PROD;
      S_PROD: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_LSTART: state_nxt = S_LNORM;
      S_LNORM: begin
        if (orv[slqv_pkg::NRM_BITS-1]) begin
          state_nxt = S_LSQR;
        end
      end
      S_LSQR:   state_nxt = S_LSUM;
      S_LSUM:   state_nxt = S_LROOT;
      S_LROOT: begin
        if (bit_r[0]) begin
          state_nxt = S_LDIVI;
        end
      end
      S_LDIVI:  state_nxt = S_LDIV;
      S_LDIV: begin
        if (cnt_r == '0) begin
          state_nxt = S_LFIN;
        end
      end
      S_LFIN: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      res_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_PROD || state_r == S_LFIN) && slot_free) begin
        res_vld_r <= 1'b1;
      end else if (res_take) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (q_vld) begin
          it_r <= q_item;
        end
      end
      S_SIN1: begin
        x2a_r <= sqa[slqv_pkg::Q16_BITS +: QB];
        x2b_r <= sqb[slqv_pkg::Q16_BITS +: QB];
      end
      S_SIN2: begin
        t1a_r <= slqv_pkg::SIN_B - ka[slqv_pkg::Q16_BITS +: slqv_pkg::Q16_BITS];
        t1b_r <= slqv_pkg::SIN_B - kb[slqv_pkg::Q16_BITS +: slqv_pkg::Q16_BITS];
      end
      S_SIN3: begin
        t2a_r <= slqv_pkg::SIN_A - ha[slqv_pkg::Q16_BITS +: QB];
        t2b_r <= slqv_pkg::SIN_A - hb[slqv_pkg::Q16_BITS +: QB];
      end
      S_SIN4: begin
        s_r <= s_nxt;
        c_r <= c_nxt;
      end
      S_PROD: begin
        if (slot_free) begin
          res_r.op   <= it_r.op;
          res_r.bx   <= {cx, {slqv_pkg::Q16_BITS{1'b0}}};
          res_r.by   <= {cy, {slqv_pkg::Q16_BITS{1'b0}}};
          res_r.p1   <= PB'(it_r.gx) * PB'(c_r);
          res_r.p2   <= PB'(it_r.gy) * PB'(s_r);
          res_r.p3   <= PB'(it_r.gx) * PB'(s_r);
          res_r.p4   <= PB'(it_r.gy) * PB'(c_r);
          res_r.u0   <= it_r.u0;
          res_r.v0   <= it_r.v0;
          res_r.u1   <= it_r.u1;
          res_r.v1   <= it_r.v1;
          res_r.rgba <= it_r.rgba;
        end
      end
      S_LSTART: begin
        mx_r    <= slqv_pkg::NRM_BITS'(adx);
        my_r    <= slqv_pkg::NRM_BITS'(ady);
        dxneg_r <= dx[CB];
        dypos_r <= !dy[CB] && (dy != '0);
      end
      S_LNORM: begin
        if (!orv[slqv_pkg::NRM_BITS-1]) begin
          if (orv[slqv_pkg::NRM_BITS-1 -: 8] == '0) begin
            mx_r <= mx_r << 8;
            my_r <= my_r << 8;
          end else begin
            mx_r <= mx_r << 1;
            my_r <= my_r << 1;
          end
        end
      end
      S_LSQR: begin
        sqx_r  <= slqv_pkg::SQ_BITS'(mx_r) * slqv_pkg::SQ_BITS'(mx_r);
        sqy_r  <= slqv_pkg::SQ_BITS'(my_r) * slqv_pkg::SQ_BITS'(my_r);
        numx_r <= slqv_pkg::NUM_BITS'(my_r) * slqv_pkg::NUM_BITS'(it_r.thick);
        numy_r <= slqv_pkg::NUM_BITS'(mx_r) * slqv_pkg::NUM_BITS'(it_r.thick);
      end
      S_LSUM: begin
        v_r    <= slqv_pkg::SUM_BITS'(sqx_r) + slqv_pkg::SUM_BITS'(sqy_r);
        root_r <= '0;
        bit_r  <= {1'b1, {slqv_pkg::SUM_BITS{1'b0}}};
      end
      S_LROOT: begin
        if ((slqv_pkg::SUM_BITS+2)'(v_r) >= trial) begin
          v_r    <= v_r - slqv_pkg::SUM_BITS'(trial);
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      S_LDIVI: begin
        remx_r <= slqv_pkg::REM_BITS'(numx_r) + slqv_pkg::REM_BITS'(len);
        remy_r <= slqv_pkg::REM_BITS'(numy_r) + slqv_pkg::REM_BITS'(len);
        dsh_r  <= slqv_pkg::DSH_BITS'({len, 1'b0}) << (slqv_pkg::DIV_Q_BITS - 1);
        cnt_r  <= slqv_pkg::CNT_BITS'(slqv_pkg::DIV_Q_BITS - 1);
      end
      S_LDIV: begin
        if (gex) begin
          remx_r <= remx_r - slqv_pkg::REM_BITS'(dsh_r);
        end
        if (gey) begin
          remy_r <= remy_r - slqv_pkg::REM_BITS'(dsh_r);
        end
        qx_r  <= {qx_r[slqv_pkg::DIV_Q_BITS-2:0], gex};
        qy_r  <= {qy_r[slqv_pkg::DIV_Q_BITS-2:0], gey};
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 1'b1;
      end
      S_LFIN: begin
        if (slot_free) begin
          res_r.op   <= it_r.op;
          res_r.fx   <= it_r.fx;
          res_r.fy   <= it_r.fy;
          res_r.gx   <= it_r.gx;
          res_r.gy   <= it_r.gy;
          res_r.nx   <= dypos_r ? -nxm : nxm;
          res_r.ny   <= dxneg_r ? -nym : nym;
          res_r.u0   <= it_r.u0;
          res_r.v0   <= it_r.v0;
          res_r.u1   <= it_r.u1;
          res_r.v1   <= it_r.v1;
          res_r.rgba <= it_r.rgba;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/slqv_emit.sv */
// corner emitter: walks the four corners of a finished job into the output register
// depends on slqv_pkg
module slqv_emit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                res_vld,
  input  slqv_pkg::job_t                      res,
  output logic                                res_take,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [slqv_pkg::COORD_BITS-1:0] out_vertex_x,
  output logic signed [slqv_pkg::COORD_BITS-1:0] out_vertex_y,
  output logic [slqv_pkg::TEX_BITS-1:0]       out_vertex_u,
  output logic [slqv_pkg::TEX_BITS-1:0]       out_vertex_v,
  output logic [slqv_pkg::RGBA_BITS-1:0]      out_vertex_rgba,
  output logic [1:0]                          out_corner_index,
  output logic                                out_last_corner
);

  localparam int AB = slqv_pkg::ACC_BITS;
  localparam int SB = slqv_pkg::SAT_IN_BITS;

  slqv_pkg::job_t job_r;
  logic           job_vld_r;
  logic [1:0]     corner_r;
  logic           out_vld_r, out_vld_nxt;
  logic signed [slqv_pkg::COORD_BITS-1:0] x_r, y_r, x_nxt, y_nxt;
  logic [slqv_pkg::TEX_BITS-1:0]  u_r, v_r;
  logic [slqv_pkg::RGBA_BITS-1:0] rgba_r;
  logic [1:0]     idx_r;
  logic           last_r;

  logic           adv, pos_x, pos_y;
  logic signed [AB-1:0] t1, t2, t3, t4, ax, ay;
  logic signed [SB-1:0] lx, ly, nxe, nye;

  assign adv      = job_vld_r && (!out_vld_r || !out_stall);
  assign res_take = res_vld && (!job_vld_r || (adv && corner_r == slqv_pkg::CORNER_LAST));
  assign pos_x    = corner_r inside {2'd1, 2'd2};
  assign pos_y    = corner_r[1];

  always_comb begin
    t1 = pos_x ? AB'(job_r.p1) : -AB'(job_r.p1);
    t2 = pos_y ? AB'(job_r.p2) : -AB'(job_r.p2);
    t3 = pos_x ? AB'(job_r.p3) : -AB'(job_r.p3);
    t4 = pos_y ? AB'(job_r.p4) : -AB'(job_r.p4);
    ax = AB'(job_r.bx) + t1 - t2 + AB'(1 <<< slqv_pkg::Q16_BITS);
    ay = AB'(job_r.by) + t3 + t4 + AB'(1 <<< slqv_pkg::Q16_BITS);
    nxe = pos_y ? -SB'(job_r.nx) : SB'(job_r.nx);
    nye = pos_y ? -SB'(job_r.ny) : SB'(job_r.ny);
    lx = (pos_x ? SB'(job_r.gx) : SB'(job_r.fx)) + nxe;
    ly = (pos_x ? SB'(job_r.gy) : SB'(job_r.fy)) + nye;
    if (job_r.op == slqv_pkg::OP_LINE) begin
      x_nxt = slqv_pkg::sat_coord(lx);
      y_nxt = slqv_pkg::sat_coord(ly);
    end else begin
      x_nxt = slqv_pkg::sat_coord(ax[AB-1:slqv_pkg::ROUND_SHIFT]);
      y_nxt = slqv_pkg::sat_coord(ay[AB-1:slqv_pkg::ROUND_SHIFT]);
    end
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
      corner_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (res_take) begin
        job_vld_r <= 1'b1;
      end else if (adv && corner_r == slqv_pkg::CORNER_LAST) begin
        job_vld_r <= 1'b0;
      end
      if (adv) begin
        corner_r <= corner_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      job_r <= res;
    end
    if (adv) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      u_r    <= pos_x ? job_r.u1 : job_r.u0;
      v_r    <= pos_y ? job_r.v1 : job_r.v0;
      rgba_r <= job_r.rgba;
      idx_r  <= corner_r;
      last_r <= (corner_r == slqv_pkg::CORNER_LAST);
    end
  end

  assign out_valid        = out_vld_r;
  assign out_vertex_x     = x_r;
  assign out_vertex_y     = y_r;
  assign out_vertex_u     = u_r;
  assign out_vertex_v     = v_r;
  assign out_vertex_rgba  = rgba_r;
  assign out_corner_index = idx_r;
  assign out_last_corner  = last_r;

endmodule

/* design/sprite_and_line_quad_vertex_gen.sv */
// sprite quad and thick line vertex generator, four vertices per primitive
// a sprite passes through the back end in a 4-step sine/cosine and one product step;
// a line goes through normalize, a 32-step square root and a 24-step divider
// four vertices leave at one per cycle while out_stall is low; zero-length lines are
// dropped at the front and give no vertex
// synchronous active-low reset clears queue, sequencer and output valid; no data reset
module sprite_and_line_quad_vertex_gen (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_operation,
  input  logic signed [slqv_pkg::COORD_BITS-1:0] in_first_x,
  input  logic signed [slqv_pkg::COORD_BITS-1:0] in_first_y,
  input  logic signed [slqv_pkg::COORD_BITS-1:0] in_second_x,
  input  logic signed [slqv_pkg::COORD_BITS-1:0] in_second_y,
  input  logic [slqv_pkg::ANGLE_BITS-1:0]        in_rotation,
  input  logic [slqv_pkg::THICK_BITS-1:0]        in_thickness,
  input  logic [slqv_pkg::TEX_BITS-1:0]          in_tex_u_start,
  input  logic [slqv_pkg::TEX_BITS-1:0]          in_tex_v_start,
  input  logic [slqv_pkg::TEX_BITS-1:0]          in_tex_u_end,
  input  logic [slqv_pkg::TEX_BITS-1:0]          in_tex_v_end,
  input  logic [slqv_pkg::RGBA_BITS-1:0]         in_colour_rgba,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [slqv_pkg::COORD_BITS-1:0] out_vertex_x,
  output logic signed [slqv_pkg::COORD_BITS-1:0] out_vertex_y,
  output logic [slqv_pkg::TEX_BITS-1:0]          out_vertex_u,
  output logic [slqv_pkg::TEX_BITS-1:0]          out_vertex_v,
  output logic [slqv_pkg::RGBA_BITS-1:0]         out_vertex_rgba,
  output logic [1:0]                             out_corner_index,
  output logic                                   out_last_corner
);

  slqv_pkg::item_t in_item, q_item;
  slqv_pkg::job_t  res;
  logic            q_vld, q_pop, res_vld, res_take;

  always_comb begin
    in_item.op    = in_operation;
    in_item.fx    = in_first_x;
    in_item.fy    = in_first_y;
    in_item.gx    = in_second_x;
    in_item.gy    = in_second_y;
    in_item.rot   = in_rotation;
    in_item.thick = in_thickness;
    in_item.u0    = in_tex_u_start;
    in_item.v0    = in_tex_v_start;
    in_item.u1    = in_tex_u_end;
    in_item.v1    = in_tex_v_end;
    in_item.rgba  = in_colour_rgba;
  end

  slqv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_vld    (q_vld),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  slqv_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_vld    (q_vld),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .res_vld  (res_vld),
    .res      (res),
    .res_take (res_take)
  );

  slqv_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_vld          (res_vld),
    .res              (res),
    .res_take         (res_take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_vertex_x     (out_vertex_x),
    .out_vertex_y     (out_vertex_y),
    .out_vertex_u     (out_vertex_u),
    .out_vertex_v     (out_vertex_v),
    .out_vertex_rgba  (out_vertex_rgba),
    .out_corner_index (out_corner_index),
    .out_last_corner  (out_last_corner)
  );

endmodule

/* tb/tb_top.sv */
// testbench for the sprite and line quad vertex generator: directed and random primitives
// a scoreboard class predicts the four corners of each primitive; depends on slqv_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic signed [slqv_pkg::COORD_BITS-1:0] x;
    logic signed [slqv_pkg::COORD_BITS-1:0] y;
    logic [slqv_pkg::TEX_BITS-1:0]          u;
    logic [slqv_pkg::TEX_BITS-1:0]          v;
    logic [slqv_pkg::RGBA_BITS-1:0]         rgba;
    logic [1:0]                             corner;
    logic                                   last;
  } vertex_t;

  class vertex_scoreboard;
    vertex_t pending[$];
    int      mismatches;

    function longint quarter_sine(longint x);
      longint x2, t;
      x2 = (x * x) >>> 16;
      t  = 42048 - ((4640 * x2) >>> 16);
      t  = 102944 - ((x2 * t) >>> 16);
      t  = (x * t) >>> 16;
      return (t > 65536) ? 65536 : t;
    endfunction

    function longint floor_shift17(longint v);
      if (v >= 0) return v >>> 17;
      return -((-v + 131071) >>> 17);
    endfunction

    function logic signed [slqv_pkg::COORD_BITS-1:0] clamp(longint v);
      longint hi, lo;
      hi = (longint'(1) <<< (slqv_pkg::COORD_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return slqv_pkg::COORD_MAX;
      if (v < lo) return slqv_pkg::COORD_MIN;
      return v[slqv_pkg::COORD_BITS-1:0];
    endfunction

    function longint isqrt(longint unsigned v);
      longint unsigned res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w >>= 2;
      while (bit_w != 0) begin
        if (v >= res + bit_w) begin
          v = v - (res + bit_w);
          res = (res >> 1) + bit_w;
        end else begin
          res = res >> 1;
        end
        bit_w >>= 2;
      end
      return longint'(res);
    endfunction

    function void add_corner(int k, longint x, longint y, logic [15:0] u, logic [15:0] v,
                             logic [31:0] rgba);
      vertex_t e;
      e.x = clamp(x);
      e.y = clamp(y);
      e.u = u;
      e.v = v;
      e.rgba = rgba;
      e.corner = k[1:0];
      e.last = (k == 3);
      pending = {pending, e};
    endfunction

    function void note_primitive(slqv_pkg::item_t it);
      longint fx, fy, gx, gy, s, c, p, r, xq, bx, by, ox, oy;
      longint dx, dy, mx, my, big, len, nxm, nym, nx, ny, t;
      int q, k;
      fx = it.fx; fy = it.fy; gx = it.gx; gy = it.gy;
      if (it.op == slqv_pkg::OP_SPRITE) begin
        q  = it.rot[15:14];
        xq = longint'(it.rot[13:0]) <<< 2;
        p  = quarter_sine(xq);
        r  = quarter_sine(65536 - xq);
        case (q)
          0: begin s = p; c = r; end
          1: begin s = r; c = -p; end
          2: begin s = -p; c = -r; end
          default: begin s = -r; c = p; end
        endcase
        bx = (2 * fx + gx) * 65536;
        by = (2 * fy + gy) * 65536;
        for (k = 0; k < 4; k++) begin
          ox = (k == 0 || k == 3) ? -gx : gx;
          oy = (k < 2) ? -gy : gy;
          add_corner(k, floor_shift17(bx + ox * c - oy * s + 65536),
                     floor_shift17(by + ox * s + oy * c + 65536),
                     (k == 1 || k == 2) ? it.u1 : it.u0, (k >= 2) ? it.v1 : it.v0, it.rgba);
        end
      end else begin
        t = it.thick;
        dx = gx - fx; dy = gy - fy;
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        if (mx == 0 && my == 0) return;
        big = mx > my ? mx : my;
        while (big >= (longint'(1) <<< 30)) begin
          big = big >>> 1; mx = mx >>> 1; my = my >>> 1;
        end
        while (big < (longint'(1) <<< 29)) begin
          big = big <<< 1; mx = mx <<< 1; my = my <<< 1;
        end
        len = isqrt(longint'(mx * mx + my * my));
        nxm = (my * t + len) / (2 * len);
        nym = (mx * t + len) / (2 * len);
        nx = dy > 0 ? -nxm : nxm;
        ny = dx < 0 ? -nym : nym;
        add_corner(0, fx + nx, fy + ny, it.u0, it.v0, it.rgba);
        add_corner(1, gx + nx, gy + ny, it.u1, it.v0, it.rgba);
        add_corner(2, gx - nx, gy - ny, it.u1, it.v1, it.rgba);
        add_corner(3, fx - nx, fy - ny, it.u0, it.v1, it.rgba);
      end
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected vertex x=%0d y=%0d", got.x, got.y);
        return;
      end
      e = pending.pop_front();
      if (got.x !== e.x || got.y !== e.y || got.u !== e.u || got.v !== e.v ||
          got.rgba !== e.rgba || got.corner !== e.corner || got.last !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("vertex mismatch exp x=%0d y=%0d u=%h v=%h c=%h k=%0d l=%b",
                   e.x, e.y, e.u, e.v, e.rgba, e.corner, e.last,
                   " got x=%0d y=%0d u=%h v=%h c=%h k=%0d l=%b",
                   got.x, got.y, got.u, got.v, got.rgba, got.corner, got.last);
      end
    endfunction
  endclass

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall;
  slqv_pkg::item_t cur;
  logic signed [slqv_pkg::COORD_BITS-1:0] out_vertex_x, out_vertex_y;
  logic [slqv_pkg::TEX_BITS-1:0] out_vertex_u, out_vertex_v;
  logic [slqv_pkg::RGBA_BITS-1:0] out_vertex_rgba;
  logic [1:0] out_corner_index;
  logic out_last_corner;

  vertex_scoreboard sb;
  int send_idle, recv_stall, idle_cycles;
  bit timed_out;

  sprite_and_line_quad_vertex_gen u_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(cur.op), .in_first_x(cur.fx), .in_first_y(cur.fy),
    .in_second_x(cur.gx), .in_second_y(cur.gy), .in_rotation(cur.rot),
    .in_thickness(cur.thick), .in_tex_u_start(cur.u0), .in_tex_v_start(cur.v0),
    .in_tex_u_end(cur.u1), .in_tex_v_end(cur.v1), .in_colour_rgba(cur.rgba),
    .out_valid(out_valid), .out_stall(out_stall), .out_vertex_x(out_vertex_x),
    .out_vertex_y(out_vertex_y), .out_vertex_u(out_vertex_u), .out_vertex_v(out_vertex_v),
    .out_vertex_rgba(out_vertex_rgba), .out_corner_index(out_corner_index),
    .out_last_corner(out_last_corner)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    vertex_t got;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid && !in_stall) sb.note_primitive(cur);
      if (out_valid && !out_stall) begin
        got.x = out_vertex_x; got.y = out_vertex_y; got.u = out_vertex_u;
        got.v = out_vertex_v; got.rgba = out_vertex_rgba; got.corner = out_corner_index;
        got.last = out_last_corner;
        sb.check_vertex(got);
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall);
  end

  always @(posedge clk) begin
    if (idle_cycles >= 20000 && !timed_out) begin
      timed_out = 1;
      $display("** sprite_and_line_quad_vertex_gen: FAILED **");
      $finish;
    end
  end

  function automatic logic [23:0] rand_coord(int mode);
    case (mode)
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return 24'($signed($urandom_range(4096)) - 2048);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic slqv_pkg::item_t rand_primitive();
    slqv_pkg::item_t it;
    logic [255:0]    raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(slqv_pkg::item_t)-1:0];
    it.op = 1'($urandom_range(1));
    it.fx = rand_coord($urandom_range(7) < 5 ? 2 + $urandom_range(1) : $urandom_range(1));
    it.fy = rand_coord($urandom_range(7) < 5 ? 2 + $urandom_range(1) : $urandom_range(1));
    it.gx = rand_coord($urandom_range(7) < 5 ? 2 + $urandom_range(1) : $urandom_range(1));
    it.gy = rand_coord($urandom_range(7) < 5 ? 2 + $urandom_range(1) : $urandom_range(1));
    if ($urandom_range(15) == 0) begin
      it.gx = it.fx; it.gy = it.fy;
    end
    if ($urandom_range(3) == 0) it.thick = 23'($urandom_range(4096));
    return it;
  endfunction

  task automatic send_primitive(slqv_pkg::item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    cur <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  initial begin
    slqv_pkg::item_t it;
    int ph, n;
    sb = new();
    rst_n = 0; in_valid = 0; out_stall = 0; cur = '0;
    send_idle = 0; recv_stall = 0; idle_cycles = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    // directed: extremes, all quadrants, degenerate and mirrored shapes
    for (n = 0; n < 24; n++) begin
      it = '0;
      it.op = n[0];
      it.rgba = (n % 3 == 0) ? 32'hffffffff : $urandom;
      {it.u0, it.v0, it.u1, it.v1} = (n % 2) ? 64'hffffffffffffffff : {$urandom, $urandom};
      it.rot = (n < 8) ? 16'(n * 16'h2000) : ((n % 4 == 0) ? 16'hffff : 16'($urandom));
      it.thick = (n % 4 == 1) ? 23'h7fffff : 23'(32'h200 + n);
      case (n / 2)
        0: begin
          it.fx = 24'(100); it.fy = 24'(200); it.gx = 24'(400); it.gy = 24'(300);
        end
        1: begin
          it.fx = slqv_pkg::COORD_MAX; it.fy = slqv_pkg::COORD_MAX;
          it.gx = slqv_pkg::COORD_MAX; it.gy = slqv_pkg::COORD_MAX;
        end
        2: begin
          it.fx = slqv_pkg::COORD_MIN; it.fy = slqv_pkg::COORD_MIN;
          it.gx = slqv_pkg::COORD_MIN; it.gy = slqv_pkg::COORD_MAX;
        end
        3: begin
          it.fx = 24'(50); it.fy = 24'(50); it.gx = 24'(50); it.gy = 24'(50);
        end
        4: begin
          it.fx = '0; it.fy = '0; it.gx = 24'(-300); it.gy = 24'(-200);
        end
        5: begin
          it.fx = slqv_pkg::COORD_MIN; it.fy = slqv_pkg::COORD_MAX;
          it.gx = slqv_pkg::COORD_MAX; it.gy = slqv_pkg::COORD_MIN;
        end
        6: begin
          it.fx = '0; it.fy = '0; it.gx = 24'(1); it.gy = '0;
        end
        7: begin
          it.fx = '0; it.fy = '0; it.gx = '0; it.gy = 24'(-1);
        end
        default: begin
          it.fx = rand_coord(3); it.fy = rand_coord(3);
          it.gx = rand_coord(3); it.gy = rand_coord(3);
        end
      endcase
      send_primitive(it);
    end
    drain();
    for (ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? ((ph == 3) ? 10 : 68) : 0;
      recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 10 : 68) : 0;
      for (n = 0; n < 112; n++) send_primitive(rand_primitive());
      drain();
    end
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("** sprite_and_line_quad_vertex_gen: PASSED **");
    else
      $display("** sprite_and_line_quad_vertex_gen: FAILED **");
    $finish;
  end
endmodule
